// File: rtl/wsf_pkg.sv
package wsf_pkg;

  // Sizes
  localparam int PATTERN_MAX = 32;
  localparam int CHAR_W      = 8;
  localparam int PAT_REGS    = 4;
  localparam int PAT_REG_W   = 64;
  localparam int PAT_CAP     = PAT_REGS * PAT_REG_W / CHAR_W;
  localparam int PAT_USE     = (PAT_CAP < PATTERN_MAX) ? PAT_CAP : PATTERN_MAX;
  localparam int PLEN_W      = 6;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W       = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SCAN_W      = PAT_CAP * CHAR_W;
  localparam int CFG_IDX_W   = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd4;

  // Separator codes
  localparam logic [CHAR_W-1:0] SEP_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] SEP_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] SEP_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] SEP_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] SEP_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] SEP_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] SEP_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] SEP_CR     = 8'h0D;

  function automatic logic is_separator(input logic [CHAR_W-1:0] b);
    logic sep;
    unique case (b) inside
      SEP_SPACE, SEP_PERIOD, SEP_COMMA, SEP_LPAREN, SEP_RPAREN,
      SEP_BANG, SEP_LF, SEP_CR: sep = 1'b1;
      default:                  sep = 1'b0;
    endcase
    return sep;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic store;
    logic scan_load;
    logic scan_shift;
    logic emit_load;
    logic clear_word;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sep;
    logic word_pending;
    logic can_match;
    logic scan_hit;
    logic scan_done;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/word_substring_filter_core.sv
// Word filter: text bytes enter one per cycle and are split into words at
// space, period, comma, parentheses, exclamation mark, LF and CR; a flush item
// also ends the pending word. A finished word that occurs contiguously inside
// the configured pattern (up to 32 characters) is sent out one character per
// item, its last character marked by out_word_last. Word bytes, and separators
// that end no word or a word too long for the pattern, are taken without a
// stall. A separator ending a word of n characters that could fit starts an
// offset scan over pattern offsets 0 to (pattern_length - n), one pattern offset
// per cycle, and a hit then emits n items at one per cycle through the output
// register, slower when out_stall is held.
// The input side is stalled during scan and emission. Configuration writes are
// always ready; registers 0..3 hold pattern characters, 4 the pattern length.
module word_substring_filter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsf_pkg::CHAR_W-1:0]    in_byte_value,
  input  logic                          in_flush,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsf_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_word_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsf_pkg::PAT_REG_W-1:0] cfg_data
);
  import wsf_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  wsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  wsf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte_value (in_byte_value),
    .in_flush      (in_flush),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_word_last (out_word_last),
    .ctl           (ctl),
    .stat          (stat)
  );

endmodule

// File: rtl/wsf_ctrl.sv
module wsf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsf_pkg::stat_t stat,
  output wsf_pkg::ctl_t  ctl
);
  import wsf_pkg::*;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && stat.is_sep && stat.word_pending && stat.can_match) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = ST_EMIT;
        end else if (stat.scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!stat.is_sep) begin
            ctl.store = 1'b1;
          end else if (stat.word_pending) begin
            if (stat.can_match) begin
              ctl.scan_load = 1'b1;
            end else begin
              ctl.clear_word = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!stat.scan_hit) begin
          if (stat.scan_done) begin
            ctl.clear_word = 1'b1;
          end else begin
            ctl.scan_shift = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          ctl.emit_load = 1'b1;
          if (stat.emit_last) begin
            ctl.clear_word = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_load |-> stat.out_free)
    else $error("emit load while output register busy");

  // bytes are only stored while the input side is open
  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.store |-> (state_r == ST_IDLE && !in_stall))
    else $error("store outside idle");

  // input side closed during scan and emission
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input open while busy");
`endif

endmodule

// File: rtl/wsf_dp.sv
module wsf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wsf_pkg::CHAR_W-1:0]          in_byte_value,
  input  logic                                in_flush,
  input  logic                                cfg_valid,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsf_pkg::PAT_REG_W-1:0]       cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wsf_pkg::CHAR_W-1:0]          out_char,
  output logic                                out_word_last,
  input  wsf_pkg::ctl_t                       ctl,
  output wsf_pkg::stat_t                      stat
);
  import wsf_pkg::*;

  // Pattern registers
  logic [PAT_REG_W-1:0] pat_r [PAT_REGS];
  logic [PLEN_W-1:0]    plen_r;

  // Pending word
  logic [CHAR_W-1:0] wbuf_r [PATTERN_MAX];
  logic [LEN_W-1:0]  wlen_r, wlen_nxt;
  logic              wlong_r, wlong_nxt;

  // Offset scan
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Emission
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  plen_use;
  logic [CNT_W-1:0]  wlen_ext;
  logic              word_full;
  logic [PAT_USE-1:0] char_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < PAT_REGS; r++) begin
        pat_r[r] <= '0;
      end
      plen_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PAT_A:   pat_r[0] <= cfg_data;
        CFG_PAT_B:   pat_r[1] <= cfg_data;
        CFG_PAT_C:   pat_r[2] <= cfg_data;
        CFG_PAT_D:   pat_r[3] <= cfg_data;
        CFG_PAT_LEN: plen_r   <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Length in use saturates at capacity
  assign plen_use  = (plen_r > PLEN_W'(PAT_USE)) ? CNT_W'(PAT_USE) : CNT_W'(plen_r);
  assign wlen_ext  = CNT_W'(wlen_r);
  assign word_full = (wlen_r == LEN_W'(PATTERN_MAX));

  // Word store
  always_ff @(posedge clk) begin
    if (ctl.store && !word_full) begin
      wbuf_r[wlen_r[IDX_W-1:0]] <= in_byte_value;
    end
  end

  always_comb begin
    wlen_nxt  = wlen_r;
    wlong_nxt = wlong_r;
    if (ctl.clear_word) begin
      wlen_nxt  = '0;
      wlong_nxt = 1'b0;
    end else if (ctl.store) begin
      if (word_full) begin
        wlong_nxt = 1'b1;
      end else begin
        wlen_nxt = wlen_r + LEN_W'(1);
      end
    end
  end

  // Pattern window shifts one character per offset
  always_comb begin
    scan_nxt = scan_r;
    cnt_nxt  = cnt_r;
    if (ctl.scan_load) begin
      for (int r = 0; r < PAT_REGS; r++) begin
        scan_nxt[r*PAT_REG_W +: PAT_REG_W] = pat_r[r];
      end
      cnt_nxt = plen_use - wlen_ext;
    end else if (ctl.scan_shift) begin
      scan_nxt = scan_r >> CHAR_W;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  // Compare word against the window at the current offset
  always_comb begin
    for (int i = 0; i < PAT_USE; i++) begin
      char_ok[i] = (int'(wlen_r) <= i) || (wbuf_r[i] == scan_r[i*CHAR_W +: CHAR_W]);
    end
  end

  // Output register
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.clear_word) begin
      idx_nxt = '0;
    end else if (ctl.emit_load) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (ctl.emit_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_load) begin
      out_char_r <= wbuf_r[idx_r];
      out_last_r <= stat.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= '0;
      wlong_r     <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wlen_r      <= wlen_nxt;
      wlong_r     <= wlong_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  // Status
  assign stat.is_sep       = in_flush || is_separator(in_byte_value);
  assign stat.word_pending = (wlen_r != '0) || wlong_r;
  assign stat.can_match    = !wlong_r && (wlen_r != '0) && (wlen_ext <= plen_use);
  assign stat.scan_hit     = &char_ok;
  assign stat.scan_done    = (cnt_r == '0);
  assign stat.emit_last    = ((CNT_W'(idx_r) + CNT_W'(1)) == wlen_ext);
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_word_last = out_last_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= LEN_W'(PATTERN_MAX))
    else $error("word length past buffer");

  a_long_full: assert property (@(posedge clk) disable iff (!rst_n)
    wlong_r |-> word_full)
    else $error("overlong word flagged before buffer filled");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_load |=> out_valid_r)
    else $error("loaded item not presented");
`endif

endmodule

// File: test/tb_word_substring_filter_core.sv
`timescale 1ns / 1ps

module tb_word_substring_filter_core;
  import wsf_pkg::*;

  localparam int LONG_HOLD      = 90;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 36;
  localparam int NUM_PHASES     = 8;

  // Pattern fill styles
  typedef enum int {
    PAT_ALPHA,
    PAT_WORDY,
    PAT_ANY,
    PAT_ZEROS,
    PAT_ONES
  } pat_style_t;

  typedef struct packed {
    logic [CHAR_W-1:0] value;
    logic              flush;
  } text_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } emit_char_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_byte_value = '0;
  logic                 in_flush      = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_word_last;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [PAT_REG_W-1:0] cfg_data      = '0;

  // Word separators
  logic [CHAR_W-1:0] sep_codes [8] = '{SEP_SPACE, SEP_PERIOD, SEP_COMMA, SEP_LPAREN,
                                      SEP_RPAREN, SEP_BANG, SEP_LF, SEP_CR};

  // Shadow of the configuration and of the pending word
  logic [PAT_REG_W-1:0] pat_shadow [PAT_REGS];
  logic [PLEN_W-1:0]    plen_shadow = '0;
  logic [CHAR_W-1:0]    wbuf [PATTERN_MAX];
  int                   wlen  = 0;
  bit                   wlong = 1'b0;

  text_item_t pend_q [$];
  emit_char_t match_q [$];
  text_item_t drv_next;
  emit_char_t mon_want;

  int bad_count    = 0;
  int stuck_cycles = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_req     = 1'b0;
  bit idle_on      = 1'b1;

  word_substring_filter_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_flush      (in_flush),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_word_last (out_word_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bit is_word_break(input logic [CHAR_W-1:0] b);
    foreach (sep_codes[j]) begin
      if (b == sep_codes[j]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CHAR_W-1:0] pat_char(input int k);
    return pat_shadow[k / 8][CHAR_W * (k % 8) +: CHAR_W];
  endfunction

  function automatic int plen_in_use();
    return (plen_shadow > PAT_USE) ? PAT_USE : int'(plen_shadow);
  endfunction

  // Contiguous occurrence of the pending word at any pattern offset
  function automatic bit word_in_pattern();
    int  plen;
    bit  same;
    plen = plen_in_use();
    if (wlong || wlen == 0 || wlen > plen) return 1'b0;
    for (int o = 0; o + wlen <= plen; o++) begin
      same = 1'b1;
      for (int i = 0; i < wlen; i++) begin
        if (pat_char(o + i) != wbuf[i]) same = 1'b0;
      end
      if (same) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the shadow by one accepted item, queue the characters it releases
  function automatic void filter_step(input logic [CHAR_W-1:0] b, input logic fl);
    emit_char_t e;
    if (!fl && !is_word_break(b)) begin
      if (wlen < PATTERN_MAX) begin
        wbuf[wlen] = b;
        wlen++;
      end else begin
        wlong = 1'b1;
      end
    end else if (wlen != 0 || wlong) begin
      if (word_in_pattern()) begin
        for (int i = 0; i < wlen; i++) begin
          e.ch   = wbuf[i];
          e.last = (i + 1 == wlen);
          match_q.push_back(e);
        end
      end
      wlen  = 0;
      wlong = 1'b0;
    end
  endfunction

  function automatic void push_item(input logic [CHAR_W-1:0] b, input logic fl);
    text_item_t t;
    t.value = b;
    t.flush = fl;
    pend_q.push_back(t);
  endfunction

  function automatic void push_span(input int o, input int len);
    for (int k = 0; k < len; k++) push_item(pat_char(o + k), 1'b0);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_word_byte();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(0, 255));
    while (is_word_break(b)) b = CHAR_W'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [PAT_REG_W-1:0] rand_pat_data(input pat_style_t sty);
    logic [PAT_REG_W-1:0] d;
    for (int k = 0; k < PAT_REG_W / CHAR_W; k++) begin
      case (sty)
        PAT_ALPHA: d[CHAR_W * k +: CHAR_W] = CHAR_W'(8'h61 + $urandom_range(0, 2));
        PAT_WORDY: d[CHAR_W * k +: CHAR_W] = rand_word_byte();
        PAT_ZEROS: d[CHAR_W * k +: CHAR_W] = '0;
        PAT_ONES:  d[CHAR_W * k +: CHAR_W] = '1;
        default:   d[CHAR_W * k +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
      endcase
    end
    return d;
  endfunction

  // Register write; called at a rising edge, returns at the accepting edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_REG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx) inside
      CFG_PAT_A, CFG_PAT_B, CFG_PAT_C, CFG_PAT_D:
        pat_shadow[idx[$clog2(PAT_REGS)-1:0]] = d;
      CFG_PAT_LEN: plen_shadow = d[PLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input pat_style_t sty, input int len);
    logic [PAT_REG_W-1:0] d;
    @(posedge clk);
    for (int j = 0; j < PAT_REGS; j++) cfg_write(CFG_PAT_A + CFG_IDX_W'(j), rand_pat_data(sty));
    d = {$urandom, $urandom};
    d[PLEN_W-1:0] = PLEN_W'(len);
    cfg_write(CFG_PAT_LEN, d);
    // unmapped index, must be ignored
    cfg_write(CFG_PAT_LEN + CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Let the block go fully idle: nothing queued, nothing owed, scan finished
  task automatic wait_drain();
    while (pend_q.size() != 0 || in_valid || match_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random text: mostly pattern fragments, plus noise, overlong words, flushes
  task automatic gen_text(input int target);
    int                goal;
    int                plen;
    int                r;
    int                len;
    int                o;
    int                flip;
    logic [CHAR_W-1:0] b;
    goal = pend_q.size() + target;
    plen = plen_in_use();
    while (pend_q.size() < goal) begin
      r   = $urandom_range(0, 99);
      len = 0;
      if (plen > 0 && r < 65) begin
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen)
                                          : $urandom_range(1, (plen < 4) ? plen : 4);
        o    = $urandom_range(0, plen - len);
        flip = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int k = 0; k < len; k++) begin
          b = pat_char(o + k);
          if (k == flip) b = b ^ (CHAR_W'(1) << $urandom_range(0, CHAR_W - 1));
          push_item(b, 1'b0);
        end
      end else if (plen > 0 && r < 72) begin
        len = plen;
        push_span(0, plen);
      end else if (r < 80) begin
        // outgrows the word store
        len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 8);
        for (int k = 0; k < len; k++) push_item(rand_word_byte(), 1'b0);
      end else if (r < 92) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
      else push_item(sep_codes[$urandom_range(0, 7)], 1'b0);
      if ($urandom_range(0, 7) == 0) push_item(sep_codes[$urandom_range(0, 7)], 1'b0);
    end
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) filter_step(in_byte_value, in_flush);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          gap_left <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          drv_next = pend_q.pop_front();
          in_valid      <= 1'b1;
          in_byte_value <= drv_next.value;
          in_flush      <= drv_next.flush;
        end
      end
    end
  end

  // Result monitor and output stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected item: char %h last %b", out_char, out_word_last);
        end else begin
          mon_want = match_q.pop_front();
          if (out_char !== mon_want.ch || out_word_last !== mon_want.last) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       mon_want.ch, mon_want.last, out_char, out_word_last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("word_substring_filter_core verification failed");
    $finish;
  end

  initial begin
    foreach (pat_shadow[j]) pat_shadow[j] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pattern "ab", 00, FF, "cd"
    @(posedge clk);
    cfg_write(CFG_PAT_A, 64'h0000_6463_FF00_6261);
    cfg_write(CFG_PAT_B, '0);
    cfg_write(CFG_PAT_C, '0);
    cfg_write(CFG_PAT_D, '0);
    cfg_write(CFG_PAT_LEN, 64'd6);
    cfg_valid <= 1'b0;
    @(negedge clk);
    push_span(0, 2); push_item(SEP_COMMA, 1'b0);
    push_span(2, 2); push_item(SEP_LPAREN, 1'b0);
    push_span(4, 2); push_item(8'hA5, 1'b1);
    // terminators with nothing pending, then single-character words
    push_item(8'h5A, 1'b1); push_item(SEP_BANG, 1'b0);
    push_item(8'h78, 1'b0); push_item(SEP_LF, 1'b0);
    push_span(5, 1); push_item(SEP_CR, 1'b0);
    // longer than the pattern
    push_span(0, 6); push_item(8'h78, 1'b0); push_item(SEP_PERIOD, 1'b0);
    push_item(SEP_SPACE, 1'b0); push_item(SEP_RPAREN, 1'b0);

    // Random phases over several pattern settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drain();
      case (ph)
        0:       load_pattern(PAT_ALPHA, 63);
        1:       load_pattern(PAT_WORDY, 0);
        2:       load_pattern(PAT_ZEROS, 32);
        3:       load_pattern(PAT_ONES, 33);
        4:       load_pattern(PAT_ALPHA, 1);
        5:       load_pattern(PAT_WORDY, $urandom_range(2, 31));
        6:       load_pattern(PAT_ANY, $urandom_range(0, 63));
        default: load_pattern(PAT_ALPHA, 32);
      endcase
      @(negedge clk);
      idle_on = (ph != NUM_PHASES - 1) && (ph != 4);
      // long receiver hold-off while text keeps coming
      if (ph == 0) hold_req = 1'b1;
      gen_text(PHASE_ITEMS);
    end

    wait_drain();
    if (match_q.size() != 0) begin
      bad_count++;
      $display("%0d expected items never arrived", match_q.size());
    end
    if (bad_count == 0)
      $display("word_substring_filter_core verification clean");
    else
      $display("word_substring_filter_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/wsf_pkg.sv
rtl/wsf_ctrl.sv
rtl/wsf_dp.sv
rtl/word_substring_filter_core.sv
test/tb_word_substring_filter_core.sv
